[design/tlmw_pkg.sv]
// ----------------------------------------------------------------------------
// tlmw_pkg
// Shared types and constants for the tank level median window.
// ----------------------------------------------------------------------------
package tlmw_pkg;

    localparam int unsigned WINDOW_DEPTH_DEF = 16;
    localparam int unsigned ADC_SPAN_DEF     = 1024;
    localparam int unsigned CODE_W           = 10;
    localparam int unsigned MV_W             = 16;
    localparam int unsigned REF_W            = 16;
    localparam int unsigned OHM_W            = 20;

    localparam logic [REF_W-1:0] REF_MV_RST  = 16'd5000;
    localparam logic [OHM_W-1:0] TOP_OHM_RST = 20'd10000;
    localparam logic [OHM_W-1:0] BOT_OHM_RST = 20'd10000;

    localparam logic [1:0] REG_REF_MV  = 2'd0;
    localparam logic [1:0] REG_TOP_OHM = 2'd1;
    localparam logic [1:0] REG_BOT_OHM = 2'd2;

    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_OUTER,
        ST_RD_INNER,
        ST_CMP,
        ST_MUL1,
        ST_DIV1,
        ST_MUL2,
        ST_DIV2,
        ST_DIV3,
        ST_OUT
    } seq_state_t;

endpackage

[design/tlmw_ram.sv]
// ----------------------------------------------------------------------------
// tlmw_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module tlmw_ram #(
    parameter int unsigned WIDTH = 10,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata <= mem_reg[addr];
    end

endmodule

[design/tlmw_div.sv]
// ----------------------------------------------------------------------------
// tlmw_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tlmw_div #(
    parameter int unsigned NW = 48,
    parameter int unsigned DW = 21
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [NW-1:0]  numer,
    input  logic [DW-1:0]  denom,
    output logic           busy,
    output logic [NW-1:0]  quot
);

    localparam int unsigned CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg;
    logic [DW:0]   r_reg;
    logic [DW-1:0] d_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic [DW:0]   shifted;
    logic [DW:0]   diff;

    assign shifted = {r_reg[DW-1:0], q_reg[NW-1]};
    assign diff    = shifted - {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(NW);
            q_reg    <= numer;
            r_reg    <= '0;
            d_reg    <= denom;
        end else if (busy_reg) begin
            if (!diff[DW]) begin
                r_reg <= diff;
                q_reg <= {q_reg[NW-2:0], 1'b1};
            end else begin
                r_reg <= shifted;
                q_reg <= {q_reg[NW-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy = busy_reg;
    assign quot = q_reg;

endmodule

[design/tlmw_seq.sv]
// ----------------------------------------------------------------------------
// tlmw_seq
// Sequencer: writes or clears the ring, ranks slots until it finds the median, scales it.
// ----------------------------------------------------------------------------
module tlmw_seq
    import tlmw_pkg::*;
#(
    parameter int unsigned WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   in_cmd,
    input  logic [CODE_W-1:0]      in_code,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [CODE_W-1:0]      out_median,
    output logic [MV_W-1:0]        out_mv,
    output logic [$clog2(WINDOW_DEPTH+1)-1:0] out_count,
    input  logic [REF_W-1:0]       ref_mv,
    input  logic [OHM_W-1:0]       top_ohm,
    input  logic [OHM_W-1:0]       bot_ohm
);

    localparam int unsigned AW  = $clog2(WINDOW_DEPTH);
    localparam int unsigned CNW = $clog2(WINDOW_DEPTH + 1);
    localparam int unsigned SPW = $clog2(ADC_SPAN_DEF);
    localparam int unsigned P1W = REF_W + CODE_W + 4;
    localparam int unsigned TW  = P1W - SPW;
    localparam int unsigned NW  = TW + OHM_W + 1;
    localparam int unsigned DW  = OHM_W + 1;
    // tenths quotient at which the level saturates, and 2^23/10 rounded up
    localparam int unsigned QW       = 20;
    localparam int unsigned SAT_X10  = 655360;
    localparam int unsigned REC10    = 838861;
    localparam int unsigned REC10_SH = 23;

    seq_state_t state_reg, state_next;

    logic [AW-1:0]     slot_reg, slot_next;
    logic              full_reg, full_next;
    logic [AW-1:0]     i_reg, i_next;
    logic [AW-1:0]     j_reg, j_next;
    logic [CODE_W-1:0] x_reg, x_next;
    logic [CNW-1:0]    less_reg, less_next;
    logic [CNW-1:0]    leq_reg, leq_next;
    logic [CODE_W-1:0] med_reg, med_next;
    logic [NW-1:0]     acc_reg, acc_next;
    logic [MV_W-1:0]   mv_reg, mv_next;
    logic [CNW-1:0]    cnt;
    logic [CNW-1:0]    half;

    logic              ram_we;
    logic [AW-1:0]     ram_addr;
    logic [CODE_W-1:0] ram_rdata;

    logic              div_start;
    logic              div_busy;
    logic [NW-1:0]     div_numer;
    logic [DW-1:0]     div_denom;
    logic [NW-1:0]     div_quot;
    logic [2*QW-1:0]   tenth_prod;

    assign cnt  = full_reg ? CNW'(WINDOW_DEPTH) : CNW'(slot_reg);
    assign half = cnt >> 1;

    assign div_numer  = acc_reg;
    assign div_denom  = {1'b0, bot_ohm};
    assign tenth_prod = {{QW{1'b0}}, div_quot[QW-1:0]} * (2*QW)'(REC10);

    tlmw_ram #(.WIDTH(CODE_W), .DEPTH(WINDOW_DEPTH)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (in_code),
        .rdata (ram_rdata)
    );

    tlmw_div #(.NW(NW), .DW(DW)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (div_numer),
        .denom   (div_denom),
        .busy    (div_busy),
        .quot    (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            slot_reg  <= '0;
            full_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            full_reg  <= full_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg    <= i_next;
        j_reg    <= j_next;
        x_reg    <= x_next;
        less_reg <= less_next;
        leq_reg  <= leq_next;
        med_reg  <= med_next;
        acc_reg  <= acc_next;
        mv_reg   <= mv_next;
    end

    always_comb begin
        state_next = state_reg;
        slot_next  = slot_reg;
        full_next  = full_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        x_next     = x_reg;
        less_next  = less_reg;
        leq_next   = leq_reg;
        med_next   = med_reg;
        acc_next   = acc_reg;
        mv_next    = mv_reg;
        ram_we     = 1'b0;
        ram_addr   = i_reg;
        div_start  = 1'b0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                ram_addr = slot_reg;
                if (in_valid) begin
                    med_next = '0;
                    mv_next  = '0;
                    i_next   = '0;
                    if (in_cmd == CMD_CLEAR) begin
                        slot_next  = '0;
                        full_next  = 1'b0;
                        state_next = ST_OUT;
                    end else begin
                        ram_we = 1'b1;
                        if (slot_reg == AW'(WINDOW_DEPTH - 1)) begin
                            slot_next = '0;
                            full_next = 1'b1;
                        end else begin
                            slot_next = slot_reg + 1'b1;
                        end
                        state_next = ST_RD_OUTER;
                    end
                end
            end
            ST_RD_OUTER: begin
                // ram_rdata holds slot i next cycle
                ram_addr   = i_reg;
                j_next     = '0;
                less_next  = '0;
                leq_next   = '0;
                state_next = ST_RD_INNER;
            end
            ST_RD_INNER: begin
                x_next     = ram_rdata;
                ram_addr   = j_reg;
                state_next = ST_CMP;
            end
            ST_CMP: begin
                // rank x against slot j
                ram_addr = j_reg + 1'b1;
                if (ram_rdata < x_reg) less_next = less_reg + 1'b1;
                if (ram_rdata <= x_reg) leq_next = leq_reg + 1'b1;
                if (CNW'(j_reg) == cnt - 1'b1) begin
                    state_next = ST_MUL1;
                end else begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_MUL1: begin
                // x is the median when less <= half < leq
                if (less_reg <= half && half < leq_reg) begin
                    med_next   = x_reg;
                    acc_next   = NW'(P1W'(ref_mv) * P1W'(x_reg) * P1W'(4'd10));
                    state_next = ST_DIV1;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_RD_OUTER;
                end
            end
            ST_DIV1: begin
                acc_next   = NW'(acc_reg[P1W-1:SPW]);
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                acc_next   = NW'(acc_reg[TW-1:0]) * (NW'(top_ohm) + NW'(bot_ohm));
                state_next = ST_DIV2;
            end
            ST_DIV2: begin
                div_start  = 1'b1;
                state_next = ST_DIV3;
            end
            ST_DIV3: begin
                if (!div_busy) begin
                    // divide by ten through the reciprocal; saturate on large quotients or a zero bottom resistor
                    if (div_quot >= NW'(SAT_X10) || bot_ohm == '0) begin
                        mv_next = {MV_W{1'b1}};
                    end else begin
                        mv_next = MV_W'(tenth_prod >> REC10_SH);
                    end
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                out_valid = 1'b1;
                if (out_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign out_median = med_reg;
    assign out_mv     = mv_reg;
    assign out_count  = cnt;

endmodule

[design/tank_level_median_window_top.sv]
// ----------------------------------------------------------------------------
// tank_level_median_window_top
// Running median of tank-sender ADC words with millivolt scaling.
// ----------------------------------------------------------------------------
// channel   ports         word
// input     s_axis_*      tdata: sample_code[9:0]; tuser: command
// result    m_axis_*      tdata: median[9:0], mv[25:10], count[30:26]; tuser: valid
// config    APB p*        0 reference mV, 1 top ohms, 2 bottom ohms
//
// A push raises m_axis_tvalid after slot ranking through one RAM read port,
// slot by slot from slot 0 up to the slot that holds the median, then a
// bit-serial division by the bottom resistor. A clear raises it the cycle
// after it is taken. Reset is synchronous on aresetn. One word is worked
// at a time; the input stays stalled until the result word is taken.
// ----------------------------------------------------------------------------
module tank_level_median_window_top
    import tlmw_pkg::*;
#(
    parameter int unsigned WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // sample_code
    input  logic        s_axis_tuser,  // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // median_code, level_millivolts, filled_count
    output logic        m_axis_tuser,  // result_valid
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned CNW = $clog2(WINDOW_DEPTH + 1);

    logic [REF_W-1:0]  ref_mv_reg;
    logic [OHM_W-1:0]  top_ohm_reg;
    logic [OHM_W-1:0]  bot_ohm_reg;
    logic [CODE_W-1:0] med;
    logic [MV_W-1:0]   mv;
    logic [CNW-1:0]    cnt;
    logic [4:0]        cnt5;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_mv_reg  <= REF_MV_RST;
            top_ohm_reg <= TOP_OHM_RST;
            bot_ohm_reg <= BOT_OHM_RST;
        end else if (cfg_wr && paddr[1:0] == 2'b00) begin
            unique case (paddr[3:2])
                REG_REF_MV:  ref_mv_reg  <= pwdata[REF_W-1:0];
                REG_TOP_OHM: top_ohm_reg <= pwdata[OHM_W-1:0];
                REG_BOT_OHM: bot_ohm_reg <= pwdata[OHM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_REF_MV:  prdata = 32'(ref_mv_reg);
            REG_TOP_OHM: prdata = 32'(top_ohm_reg);
            REG_BOT_OHM: prdata = 32'(bot_ohm_reg);
            default:     prdata = '0;
        endcase
    end

    tlmw_seq #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_cmd     (s_axis_tuser),
        .in_code    (s_axis_tdata[CODE_W-1:0]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_median (med),
        .out_mv     (mv),
        .out_count  (cnt),
        .ref_mv     (ref_mv_reg),
        .top_ohm    (top_ohm_reg),
        .bot_ohm    (bot_ohm_reg)
    );

    assign cnt5 = 5'(cnt);
    assign m_axis_tdata = {1'b0, cnt5, mv, med};
    assign m_axis_tuser = (cnt != '0);

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tank level median window. Drives push and clear
// words with random gaps, predicts the median, millivolt level and fill count
// of each word, and compares every result word against that prediction
// across several register settings.
// ----------------------------------------------------------------------------
module tb_top;
    import tlmw_pkg::*;

    localparam int unsigned DEPTH     = 16;
    localparam int unsigned SPAN      = 1024;
    localparam int unsigned STALL_MAX = 200000;

    typedef struct packed {
        logic              cmd;
        logic [CODE_W-1:0] code;
    } sample_word_t;

    typedef struct packed {
        logic [CODE_W-1:0] median;
        logic [MV_W-1:0]   mv;
        logic [4:0]        count;
        logic              valid;
    } level_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    sample_word_t pending_words[$];
    level_word_t  expected_levels[$];
    int unsigned  error_count = 0;
    int unsigned  idle_cycles = 0;
    int unsigned  send_idle_pct = 0;
    int unsigned  recv_idle_pct = 0;

    // predictor state
    logic [CODE_W-1:0] ring_copy[DEPTH];
    int unsigned       slot_copy = 0;
    bit                full_copy = 1'b0;
    longint unsigned   ref_mv_copy = REF_MV_RST;
    longint unsigned   top_copy = TOP_OHM_RST;
    longint unsigned   bot_copy = BOT_OHM_RST;

    tank_level_median_window_top DUT (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
        error_count++;
    endtask

    function automatic level_word_t predict_level(sample_word_t w);
        level_word_t       r;
        logic [CODE_W-1:0] buf_sorted[DEPTH];
        logic [CODE_W-1:0] x;
        int unsigned       n, j;
        longint unsigned   t, v;
        r = '0;
        if (w.cmd == CMD_CLEAR) begin
            slot_copy = 0;
            full_copy = 1'b0;
        end else begin
            ring_copy[slot_copy] = w.code;
            slot_copy++;
            if (slot_copy >= DEPTH) begin
                slot_copy = 0;
                full_copy = 1'b1;
            end
        end
        n = full_copy ? DEPTH : slot_copy;
        if (n > 0) begin
            for (int i = 0; i < n; i++) begin
                x = ring_copy[i];
                j = i;
                while (j > 0 && buf_sorted[j-1] > x) begin
                    buf_sorted[j] = buf_sorted[j-1];
                    j--;
                end
                buf_sorted[j] = x;
            end
            r.median = buf_sorted[n/2];
            if (bot_copy == 0) begin
                v = 65535;
            end else begin
                t = (ref_mv_copy * r.median * 10) / SPAN;
                v = (t * (top_copy + bot_copy)) / bot_copy / 10;
            end
            r.mv = (v > 65535) ? 16'hFFFF : v[15:0];
            r.valid = 1'b1;
        end
        r.count = n[4:0];
        return r;
    endfunction

    // driver: one word in flight from the pending queue
    always @(posedge aclk) begin
        sample_word_t w;
        sample_word_t taken;
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                taken.cmd  = s_axis_tuser;
                taken.code = s_axis_tdata[CODE_W-1:0];
                expected_levels.push_back(predict_level(taken));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_words.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                    w = pending_words.pop_front();
                    s_axis_tdata  <= {6'b0, w.code};
                    s_axis_tuser  <= w.cmd;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        level_word_t got, want;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = level_word_t'({m_axis_tdata[9:0], m_axis_tdata[25:10],
                                     m_axis_tdata[30:26], m_axis_tuser});
                if (expected_levels.size() == 0) begin
                    report_mismatch("unexpected result word", m_axis_tdata, 0);
                end else begin
                    want = expected_levels.pop_front();
                    if (got.median != want.median)
                        report_mismatch("median_code", got.median, want.median);
                    if (got.mv != want.mv)
                        report_mismatch("level_millivolts", got.mv, want.mv);
                    if (got.count != want.count)
                        report_mismatch("filled_count", got.count, want.count);
                    if (got.valid != want.valid)
                        report_mismatch("result_valid", got.valid, want.valid);
                end
            end
            m_axis_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_MAX) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_REF_MV:  ref_mv_copy = value[15:0];
            REG_TOP_OHM: top_copy = value[19:0];
            REG_BOT_OHM: bot_copy = value[19:0];
            default: ;
        endcase
    endtask

    task automatic drain_all();
        while (pending_words.size() > 0 || s_axis_tvalid || expected_levels.size() > 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    function automatic sample_word_t push_word(input logic [CODE_W-1:0] c);
        return '{cmd: CMD_PUSH, code: c};
    endfunction

    task automatic queue_random(input int unsigned items);
        sample_word_t w;
        for (int i = 0; i < items; i++) begin
            w.code = 10'($urandom_range(1023, 0));
            // mostly pushes; bias some codes to the rails
            case ($urandom_range(9, 0))
                0: w.code = 10'h000;
                1: w.code = 10'h3FF;
                default: ;
            endcase
            w.cmd = ($urandom_range(39, 0) == 0) ? CMD_CLEAR : CMD_PUSH;
            pending_words.push_back(w);
        end
    endtask

    task automatic random_settings();
        write_reg(REG_REF_MV, $urandom_range(65535, 1));
        write_reg(REG_TOP_OHM, $urandom_range(1000000, 0));
        write_reg(REG_BOT_OHM, $urandom_range(1000000, 1));
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty window, rails, wrap, clear with garbage code
        pending_words.push_back('{cmd: CMD_CLEAR, code: 10'h3FF});
        pending_words.push_back(push_word(10'h3FF));
        pending_words.push_back(push_word(10'h000));
        pending_words.push_back(push_word(10'h155));
        pending_words.push_back(push_word(10'h2AA));
        for (int i = 0; i < 14; i++)
            pending_words.push_back(push_word(10'(i * 73)));
        pending_words.push_back('{cmd: CMD_CLEAR, code: 10'h2AA});
        pending_words.push_back(push_word(10'h200));
        drain_all();

        // extremes: full scale with saturation, then zero top resistor
        write_reg(REG_REF_MV, 32'd65535);
        write_reg(REG_TOP_OHM, 32'd1000000);
        write_reg(REG_BOT_OHM, 32'd1);
        pending_words.push_back(push_word(10'h3FF));
        pending_words.push_back(push_word(10'h001));
        drain_all();
        write_reg(REG_REF_MV, 32'd1);
        write_reg(REG_TOP_OHM, 32'd0);
        write_reg(REG_BOT_OHM, 32'd1000000);
        pending_words.push_back(push_word(10'h3FF));
        drain_all();
        write_reg(REG_REF_MV, 32'd5000);
        write_reg(REG_TOP_OHM, 32'd10000);
        write_reg(REG_BOT_OHM, 32'd10000);

        send_idle_pct = 8;
        recv_idle_pct = 82;
        queue_random(450);
        drain_all();
        random_settings();
        send_idle_pct = 82;
        recv_idle_pct = 8;
        queue_random(450);
        drain_all();
        random_settings();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(450);
        drain_all();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
